/* design/skrl_pkg.sv */
`timescale 1ns / 1ps

package skrl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 64;

    // Arithmetic width of keys, differences and the step.
    localparam int CALC_BITS = 64;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    // Signed probe index, which runs from -1 to the entry count.
    localparam int PIDX_W    = CNT_W + 1;

    // Fixed field widths at the ports.
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int FIELD_KEY_W   = 64;
    localparam int FIRST_INDEX_W = 10;
    localparam int RUN_COUNT_W   = 11;
    localparam int S_TDATA_W     = 136;
    localparam int M_TDATA_W     = 88;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_FULL,
        CMD_EMPTY,
        CMD_APP_WR,
        CMD_APP_FIN,
        CMD_LO_RD,
        CMD_LO_TAKE,
        CMD_HI_RD,
        CMD_HI_TAKE,
        CMD_GUESS,
        CMD_GUESS_TAKE,
        CMD_PROBE,
        CMD_CMP,
        CMD_SRCH_END,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
        logic    lo_neg;
        logic    hi_neg;
        logic    guess_div;
        logic    div_busy;
        logic    in_range;
        logic    cmp_stop;
        logic    head_fail;
        logic    tail_mode;
        logic    out_valid;
    } t_dp_status;

    function automatic logic signed [CALC_BITS-1:0] key_ext(input logic [KEY_BITS-1:0] k);
        logic signed [KEY_BITS-1:0] s;
        s = k;
        return CALC_BITS'(s);
    endfunction

endpackage

/* design/skrl_div.sv */
`timescale 1ns / 1ps

module skrl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skrl_pkg::CALC_BITS-1:0] i_dividend,
    input  logic [skrl_pkg::CALC_BITS-1:0] i_divisor,
    output logic                          o_busy,
    output logic [skrl_pkg::CALC_BITS-1:0] o_quotient
);
    import skrl_pkg::*;

    localparam int DC_W = $clog2(CALC_BITS + 1);

    logic [CALC_BITS-1:0] r_rem;
    logic [CALC_BITS-1:0] r_quo;
    logic [CALC_BITS-1:0] r_dvs;
    logic [DC_W-1:0]      r_cnt;
    logic                 r_busy;
    logic [CALC_BITS:0]   trial;
    logic                 take;

    // One quotient bit per cycle, restoring form.
    assign trial = {r_rem, r_quo[CALC_BITS-1]};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DC_W'(CALC_BITS);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= CALC_BITS'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[CALC_BITS-1:0];
            end
            r_quo <= {r_quo[CALC_BITS-2:0], take};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DC_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

/* design/skrl_ctrl.sv */
`timescale 1ns / 1ps

module skrl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  skrl_pkg::t_dp_status i_st,
    output skrl_pkg::t_cmd       o_cmd
);
    import skrl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_APP_DIV,
        S_LO,
        S_LO_TAKE,
        S_HI,
        S_HI_TAKE,
        S_GUESS,
        S_GUESS_DIV,
        S_PROBE,
        S_CMP,
        S_SRCH_END,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_st.action)
                    ACT_APPEND: begin
                        if (i_st.full) begin
                            o_cmd   = CMD_FULL;
                            n_state = S_FINISH;
                        end else begin
                            o_cmd   = CMD_APP_WR;
                            n_state = S_APP_DIV;
                        end
                    end
                    ACT_QUERY: begin
                        if (i_st.empty) begin
                            o_cmd   = CMD_EMPTY;
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_LO;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_APP_DIV: begin
                if (!i_st.div_busy) begin
                    o_cmd   = CMD_APP_FIN;
                    n_state = S_FINISH;
                end
            end
            S_LO: begin
                if (i_st.lo_neg) begin
                    o_cmd   = CMD_LO_RD;
                    n_state = S_LO_TAKE;
                end else begin
                    n_state = S_HI;
                end
            end
            S_LO_TAKE: begin
                o_cmd   = CMD_LO_TAKE;
                n_state = S_HI;
            end
            S_HI: begin
                o_cmd   = CMD_HI_RD;
                n_state = i_st.hi_neg ? S_HI_TAKE : S_GUESS;
            end
            S_HI_TAKE: begin
                o_cmd   = CMD_HI_TAKE;
                n_state = S_GUESS;
            end
            S_GUESS: begin
                o_cmd   = CMD_GUESS;
                n_state = i_st.guess_div ? S_GUESS_DIV : S_PROBE;
            end
            S_GUESS_DIV: begin
                if (!i_st.div_busy) begin
                    o_cmd   = CMD_GUESS_TAKE;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd   = CMD_PROBE;
                n_state = i_st.in_range ? S_CMP : S_SRCH_END;
            end
            S_CMP: begin
                o_cmd   = CMD_CMP;
                n_state = i_st.cmp_stop ? S_SRCH_END : S_PROBE;
            end
            S_SRCH_END: begin
                o_cmd = CMD_SRCH_END;
                if (!i_st.tail_mode && !i_st.head_fail) begin
                    n_state = S_GUESS;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_st.out_valid) begin
                    o_cmd   = CMD_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    // Ready is registered; it stays low on the first cycle after reset and
    // otherwise follows the idle state.
    assign o_s_tready = r_ready && (r_state == S_IDLE);

endmodule

/* design/skrl_dp.sv */
`timescale 1ns / 1ps

module skrl_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  skrl_pkg::t_cmd                      i_cmd,
    input  logic [skrl_pkg::ACTION_W-1:0]       i_action,
    input  logic [skrl_pkg::FIELD_KEY_W-1:0]    i_key_low,
    input  logic [skrl_pkg::FIELD_KEY_W-1:0]    i_key_high,
    input  logic                                i_take_previous,
    output skrl_pkg::t_dp_status                o_st,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [skrl_pkg::STATUS_W-1:0]       o_status,
    output logic [skrl_pkg::FIRST_INDEX_W-1:0]  o_first_index,
    output logic [skrl_pkg::RUN_COUNT_W-1:0]    o_run_count,
    output logic [skrl_pkg::FIELD_KEY_W-1:0]    o_first_key
);
    import skrl_pkg::*;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    typedef enum logic [1:0] {
        SR_OK,
        SR_NEAR,
        SR_BELOW,
        SR_ABOVE
    } t_srch;

    logic [KEY_BITS-1:0]         r_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]         r_rd;
    logic [IDX_W-1:0]            rd_addr;

    t_action                     r_action;
    logic signed [CALC_BITS-1:0] r_lo;
    logic signed [CALC_BITS-1:0] r_hi;
    logic                        r_prev;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [CALC_BITS-1:0] r_first;
    logic signed [CALC_BITS-1:0] r_last;
    logic [CALC_BITS-1:0]        r_step;
    logic                        r_neg;
    logic                        r_tail_mode;
    logic signed [PIDX_W-1:0]    r_i;
    logic signed [PIDX_W-1:0]    r_pos;
    t_dir                        r_dir;
    logic                        r_hits;
    t_srch                       r_res;
    logic [IDX_W-1:0]            r_head;
    logic [IDX_W-1:0]            r_tail;
    t_status                     r_code;
    logic                        r_found;

    logic                        r_out_valid;
    t_status                     r_out_status;
    logic [FIRST_INDEX_W-1:0]    r_out_index;
    logic [RUN_COUNT_W-1:0]      r_out_run;
    logic [FIELD_KEY_W-1:0]      r_out_key;

    logic                        div_start;
    logic [CALC_BITS-1:0]        div_dividend;
    logic [CALC_BITS-1:0]        div_divisor;
    logic                        div_busy;
    logic [CALC_BITS-1:0]        div_quo;

    logic [CNT_W-1:0]            n_m1;
    logic signed [CALC_BITS-1:0] first_new;
    logic [CALC_BITS-1:0]        app_diff;
    logic [CALC_BITS-1:0]        app_mag;
    logic [CALC_BITS-1:0]        lo_back;
    logic [IDX_W-1:0]            lo_at;
    logic signed [CALC_BITS-1:0] k_cur;
    logic signed [CALC_BITS-1:0] ts;
    logic                        k_at_first;
    logic                        k_at_last;
    logic                        step_bad;
    logic                        guess_div;
    logic [CNT_W-1:0]            guess_idx;
    logic                        in_range;

    logic                        cmp_stop;
    logic signed [PIDX_W-1:0]    nx_i;
    logic signed [PIDX_W-1:0]    nx_pos;
    t_dir                        nx_dir;
    logic                        nx_hits;
    t_srch                       nx_res;

    logic [CNT_W-1:0]            head_val;
    logic                        head_fail;
    logic [CNT_W-1:0]            tail_val;
    logic                        tail_fail;
    logic signed [PIDX_W-1:0]    pos_inc;

    skrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign n_m1      = r_cnt - 1'b1;
    assign first_new = (r_cnt == '0) ? r_lo : r_first;
    assign app_diff  = r_lo - first_new;
    assign app_mag   = app_diff[CALC_BITS-1] ? (~app_diff + 1'b1) : app_diff;
    assign lo_back   = ~r_lo + 1'b1;
    assign lo_at     = (lo_back >= CALC_BITS'(r_cnt)) ? '0
                     : IDX_W'(CALC_BITS'(r_cnt) - lo_back);

    assign k_cur      = r_tail_mode ? r_hi : r_lo;
    assign ts         = key_ext(r_rd);
    assign k_at_first = k_cur <= r_first;
    assign k_at_last  = k_cur >= r_last;
    assign step_bad   = r_step[CALC_BITS-1] || (r_step < CALC_BITS'(2));
    assign guess_div  = !k_at_first && !k_at_last && !step_bad;
    assign guess_idx  = (!k_at_first && k_at_last) ? n_m1 : '0;
    assign in_range   = (r_i >= 0) && (r_i < $signed({1'b0, r_cnt}));

    // Divider is shared by the step update and the interpolated guess.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = app_mag;
        div_divisor  = CALC_BITS'(r_cnt) + 1'b1;
        if (i_cmd == CMD_APP_WR) begin
            div_start = 1'b1;
        end else if (i_cmd == CMD_GUESS && guess_div) begin
            div_start    = 1'b1;
            div_dividend = k_cur - r_first;
            div_divisor  = r_step;
        end
    end

    always_comb begin
        unique case (i_cmd)
            CMD_LO_RD:  rd_addr = lo_at;
            CMD_HI_RD:  rd_addr = n_m1[IDX_W-1:0];
            CMD_PROBE:  rd_addr = r_i[IDX_W-1:0];
            default:    rd_addr = r_head;
        endcase
    end

    // One probe of the linear walk.
    always_comb begin
        cmp_stop = 1'b0;
        nx_i     = r_i;
        nx_pos   = r_pos;
        nx_dir   = r_dir;
        nx_hits  = r_hits;
        nx_res   = r_res;
        if (ts < k_cur) begin
            if (r_hits) begin
                cmp_stop = 1'b1;
                nx_res   = SR_OK;
            end else if (r_dir == DIR_DOWN) begin
                cmp_stop = 1'b1;
                nx_pos   = r_i;
                nx_res   = SR_NEAR;
            end else begin
                nx_dir = DIR_UP;
                nx_i   = r_i + 1'b1;
            end
        end else if (ts > k_cur) begin
            if (r_hits) begin
                cmp_stop = 1'b1;
                nx_res   = SR_OK;
            end else if (r_dir == DIR_UP) begin
                cmp_stop = 1'b1;
                nx_pos   = r_i - 1'b1;
                nx_res   = SR_NEAR;
            end else begin
                nx_dir = DIR_DOWN;
                nx_i   = r_i - 1'b1;
            end
        end else begin
            nx_hits = 1'b1;
            nx_pos  = r_i;
            if (r_tail_mode) begin
                if (r_dir == DIR_DOWN) begin
                    cmp_stop = 1'b1;
                    nx_res   = SR_OK;
                end else begin
                    nx_dir = DIR_UP;
                    nx_i   = r_i + 1'b1;
                end
            end else begin
                if (r_dir == DIR_UP) begin
                    cmp_stop = 1'b1;
                    nx_res   = SR_OK;
                end else begin
                    nx_dir = DIR_DOWN;
                    nx_i   = r_i - 1'b1;
                end
            end
        end
    end

    assign pos_inc = r_pos + 1'b1;

    always_comb begin
        head_fail = 1'b0;
        unique case (r_res)
            SR_BELOW: head_val = '0;
            SR_ABOVE: begin
                head_val  = n_m1;
                head_fail = !r_prev;
            end
            SR_NEAR: begin
                if (r_prev) begin
                    head_val = CNT_W'(r_pos);
                end else if (pos_inc < $signed({1'b0, n_m1})) begin
                    head_val = CNT_W'(pos_inc);
                end else begin
                    head_val = n_m1;
                end
            end
            default: head_val = CNT_W'(r_pos);
        endcase
    end

    always_comb begin
        tail_fail = 1'b0;
        unique case (r_res)
            SR_BELOW: begin
                tail_val  = '0;
                tail_fail = 1'b1;
            end
            SR_ABOVE: tail_val = n_m1;
            default:  tail_val = CNT_W'(r_pos);
        endcase
        if (CNT_W'(r_head) > tail_val) begin
            tail_fail = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_APP_WR) begin
            r_mem[r_cnt[IDX_W-1:0]] <= r_lo[KEY_BITS-1:0];
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_tail_mode <= 1'b0;
            r_action    <= ACT_NOP;
            r_code      <= ST_DONE;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                CMD_LOAD: begin
                    r_action    <= t_action'(i_action);
                    r_lo        <= key_ext(i_key_low[KEY_BITS-1:0]);
                    r_hi        <= key_ext(i_key_high[KEY_BITS-1:0]);
                    r_prev      <= i_take_previous;
                    r_tail_mode <= 1'b0;
                    r_code      <= ST_DONE;
                    r_found     <= 1'b0;
                    if (t_action'(i_action) == ACT_CLEAR) begin
                        r_cnt   <= '0;
                        r_first <= '0;
                        r_last  <= '0;
                        r_step  <= '0;
                    end
                end
                CMD_FULL:  r_code <= ST_FULL;
                CMD_EMPTY: r_code <= ST_NONE;
                CMD_APP_WR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_first <= first_new;
                    r_last  <= r_lo;
                    r_neg   <= app_diff[CALC_BITS-1];
                end
                CMD_APP_FIN: begin
                    r_step <= r_neg ? (~div_quo + 1'b1) : div_quo;
                end
                CMD_LO_TAKE: r_lo <= ts;
                CMD_HI_RD: begin
                    if (r_hi == '0) begin
                        r_hi <= r_lo;
                    end
                end
                CMD_HI_TAKE: r_hi <= ts;
                CMD_GUESS: begin
                    r_i    <= $signed({1'b0, guess_idx});
                    r_pos  <= '1;
                    r_dir  <= DIR_NONE;
                    r_hits <= 1'b0;
                end
                CMD_GUESS_TAKE: begin
                    if (div_quo > CALC_BITS'(n_m1)) begin
                        r_i <= $signed({1'b0, n_m1});
                    end else begin
                        r_i <= $signed({1'b0, div_quo[CNT_W-1:0]});
                    end
                end
                CMD_PROBE: begin
                    if (!in_range) begin
                        if (r_hits) begin
                            r_res <= SR_OK;
                        end else if (r_i < 0) begin
                            r_res <= SR_BELOW;
                        end else begin
                            r_res <= SR_ABOVE;
                        end
                    end
                end
                CMD_CMP: begin
                    r_i    <= nx_i;
                    r_pos  <= nx_pos;
                    r_dir  <= nx_dir;
                    r_hits <= nx_hits;
                    r_res  <= nx_res;
                end
                CMD_SRCH_END: begin
                    if (!r_tail_mode) begin
                        r_head      <= head_val[IDX_W-1:0];
                        r_tail_mode <= 1'b1;
                        if (head_fail) begin
                            r_code <= ST_NONE;
                        end
                    end else begin
                        r_tail <= tail_val[IDX_W-1:0];
                        if (tail_fail) begin
                            r_code <= ST_NONE;
                        end else begin
                            r_found <= 1'b1;
                        end
                    end
                end
                CMD_RESULT: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload; the key at the head was read on the cycle before.
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_RESULT) begin
            r_out_status <= r_code;
            if (r_found) begin
                r_out_index <= FIRST_INDEX_W'(r_head);
                r_out_run   <= RUN_COUNT_W'(CNT_W'(r_tail) - CNT_W'(r_head) + 1'b1);
                r_out_key   <= FIELD_KEY_W'(ts);
            end else begin
                r_out_index <= '0;
                r_out_run   <= '0;
                r_out_key   <= '0;
            end
        end
    end

    assign o_st.action    = r_action;
    assign o_st.full      = (r_cnt >= CNT_W'(TABLE_DEPTH));
    assign o_st.empty     = (r_cnt == '0);
    assign o_st.lo_neg    = r_lo[CALC_BITS-1];
    assign o_st.hi_neg    = r_hi[CALC_BITS-1];
    assign o_st.guess_div = guess_div;
    assign o_st.div_busy  = div_busy;
    assign o_st.in_range  = in_range;
    assign o_st.cmp_stop  = cmp_stop;
    assign o_st.head_fail = head_fail;
    assign o_st.tail_mode = r_tail_mode;
    assign o_st.out_valid = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_index = r_out_index;
    assign o_run_count   = r_out_run;
    assign o_first_key   = r_out_key;

endmodule

/* design/sorted_key_range_lookup.sv */
`timescale 1ns / 1ps

// Channel   Direction  tuser              tdata (lowest bit first)
// s_*       in         action [1:0]       key_low [63:0], key_high [127:64],
//                                         take_previous [128], zero [135:129]
// m_*       out        status [1:0]       first_index [9:0], run_count [20:10],
//                                         first_key [84:21], zero [87:85]
//
// One item is worked at a time. A clear or an unused action goes straight to the
// result; an append waits for the step divider. A query searches for the head and,
// unless that fails, for the tail; each search uses the divider when the interpolated
// guess needs it, and then walks the key memory one probe at a time.
// Reset is synchronous and active low; the key memory is not cleared.
// A new item is taken while a finished result still waits; its own result waits
// until the output register is free.

module sorted_key_range_lookup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // key_low, key_high, take_previous, zero fill
    input  logic [skrl_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // action
    input  logic [skrl_pkg::ACTION_W-1:0]      i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // first_index, run_count, first_key, zero fill
    output logic [skrl_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // status
    output logic [skrl_pkg::STATUS_W-1:0]      o_m_tuser
);
    import skrl_pkg::*;

    t_cmd                     cmd;
    t_dp_status               st;
    logic [FIRST_INDEX_W-1:0] first_index;
    logic [RUN_COUNT_W-1:0]   run_count;
    logic [FIELD_KEY_W-1:0]   first_key;

    skrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    skrl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_s_tuser),
        .i_key_low       (i_s_tdata[63:0]),
        .i_key_high      (i_s_tdata[127:64]),
        .i_take_previous (i_s_tdata[128]),
        .o_st            (st),
        .o_out_valid     (o_m_tvalid),
        .i_out_ready     (i_m_tready),
        .o_status        (o_m_tuser),
        .o_first_index   (first_index),
        .o_run_count     (run_count),
        .o_first_key     (first_key)
    );

    assign o_m_tdata = {3'b000, first_key, run_count, first_index};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import skrl_pkg::*;

    localparam int STALL_LIMIT = 60000;

    typedef enum int {FIND_OK, FIND_NEAR, FIND_BELOW, FIND_ABOVE} t_find;

    typedef struct {
        t_status     status;
        logic [9:0]  first_index;
        logic [10:0] run_count;
        longint      first_key;
    } t_lookup_result;

    // Tracks the key table the way the block should, and keeps the lookup
    // results that are still owed by the block in arrival order.
    class lookup_scoreboard;
        longint         keys[TABLE_DEPTH];
        int             count;
        longint         head_key;
        longint         tail_key;
        logic [63:0]    step;
        t_lookup_result owed[$];
        int             errors;

        function new();
            count = 0; head_key = 0; tail_key = 0; step = 0; errors = 0;
        endfunction

        function int start_guess(longint k);
            logic [63:0] q;
            if (k <= head_key) return 0;
            if (k >= tail_key) return count - 1;
            if (step[63] || step < 2) return 0;
            q = (k - head_key) / step;
            if (q > count - 1) return count - 1;
            return int'(q);
        endfunction

        // Walks from the interpolated guess; to_tail selects the tail search.
        function t_find walk(longint k, bit to_tail, output int pos);
            int i;
            int dir;
            int hits;
            longint kv;
            i = start_guess(k);
            dir = 0;
            hits = 0;
            pos = -1;
            while (i >= 0 && i < count) begin
                kv = keys[i];
                if (kv < k) begin
                    if (hits > 0) return FIND_OK;
                    if (dir == -1) begin
                        pos = i;
                        return FIND_NEAR;
                    end
                    dir = 1; i++;
                end else if (kv > k) begin
                    if (hits > 0) return FIND_OK;
                    if (dir == 1) begin
                        pos = i - 1;
                        return FIND_NEAR;
                    end
                    dir = -1; i--;
                end else begin
                    hits++;
                    pos = i;
                    if (to_tail) begin
                        if (dir == -1) return FIND_OK;
                        dir = 1; i++;
                    end else begin
                        if (dir == 1) return FIND_OK;
                        dir = -1; i--;
                    end
                end
            end
            if (hits > 0) return FIND_OK;
            return (i < 0) ? FIND_BELOW : FIND_ABOVE;
        endfunction

        function void note_transfer(t_action act, longint lo, longint hi, bit prev);
            t_lookup_result r;
            logic [63:0] diff, mag, q, back;
            int head, tail, at;
            t_find f;
            r = '{ST_DONE, '0, '0, 0};
            case (act)
                ACT_CLEAR: begin
                    count = 0; head_key = 0; tail_key = 0; step = 0;
                end
                ACT_APPEND: begin
                    if (count >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[count] = lo;
                        count++;
                        head_key = keys[0];
                        tail_key = keys[count-1];
                        diff = tail_key - head_key;
                        mag = diff[63] ? -diff : diff;
                        q = mag / count;
                        step = diff[63] ? -q : q;
                    end
                end
                ACT_QUERY: begin
                    r.status = ST_NONE;
                    if (count >= 1) begin
                        // A negative low bound counts back from the end of the table.
                        if (lo <= -1) begin
                            back = -lo;
                            at = (back >= count) ? 0 : count - int'(back);
                            lo = keys[at];
                        end
                        if (hi <= -1) hi = keys[count-1];
                        else if (hi == 0) hi = lo;
                        f = walk(lo, 1'b0, head);
                        if (f == FIND_BELOW) head = 0;
                        else if (f == FIND_ABOVE) head = prev ? count - 1 : -1;
                        else if (f == FIND_NEAR && !prev)
                            head = (head + 1 < count - 1) ? head + 1 : count - 1;
                        if (head >= 0) begin
                            f = walk(hi, 1'b1, tail);
                            if (f == FIND_ABOVE) tail = count - 1;
                            if (f != FIND_BELOW && tail >= 0 && head <= tail
                                    && head < count) begin
                                r.status      = ST_DONE;
                                r.first_index = head[9:0];
                                r.run_count   = 11'(tail - head + 1);
                                r.first_key   = keys[head];
                            end
                        end
                    end
                end
                default: ;
            endcase
            owed.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [9:0] idx, logic [10:0] run,
                                   logic [63:0] key);
            t_lookup_result e;
            if (owed.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (idx !== e.first_index) begin
                $error("first_index expected %0d actual %0d", e.first_index, idx);
                errors++;
            end
            if (run !== e.run_count) begin
                $error("run_count expected %0d actual %0d", e.run_count, run);
                errors++;
            end
            if (key !== e.first_key) begin
                $error("first_key expected %0d actual %0d", e.first_key, $signed(key));
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // key_low, key_high, take_previous, zero fill (lowest bit first)
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    // action
    logic [ACTION_W-1:0]  i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // first_index, run_count, first_key, zero fill (lowest bit first)
    logic [M_TDATA_W-1:0] o_m_tdata;
    // status
    logic [STATUS_W-1:0]  o_m_tuser;

    lookup_scoreboard sb = new();
    int send_idle_pct = 21;
    int recv_idle_pct = 84;
    int quiet_cycles = 0;
    int sent = 0;

    sorted_key_range_lookup u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Output side: check each transfer and stall at the current rate.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata[9:0], o_m_tdata[20:10],
                                o_m_tdata[84:21]);
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Presents one item, waits for its transfer, then maybe leaves a gap.
    task automatic send_item(t_action act, longint lo, longint hi, bit prev);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {7'b0, prev, hi, lo};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_transfer(act, lo, hi, prev);
        sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic longint rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Bound drawn around stored keys, from the end, or anywhere; a high bound may also be zero.
    function automatic longint pick_bound(bit high_side);
        int c;
        c = $urandom_range(9);
        if (sb.count == 0 || c == 0) return rand_key();
        if (c == 1) return high_side ? 0 : -longint'($urandom_range(1, sb.count + 2));
        if (c == 2) return high_side ? -longint'($urandom_range(1, 3)) : rand_key();
        return sb.keys[$urandom_range(sb.count - 1)] + $signed($urandom_range(4)) - 2;
    endfunction

    task automatic random_phase(int items);
        int stop_at, n;
        longint k;
        stop_at = sent + items;
        while (sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                // Noise: any action, any fields.
                send_item(t_action'($urandom_range(3)), rand_key(), rand_key(),
                          $urandom_range(1));
            end else begin
                send_item(ACT_CLEAR, rand_key(), rand_key(), $urandom_range(1));
                n = ($urandom_range(7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
                k = ($urandom_range(3) == 0) ? rand_key() : $signed($urandom()) - 1000;
                repeat (n) begin
                    send_item(ACT_APPEND, k, rand_key(), $urandom_range(1));
                    case ($urandom_range(5))
                        0: k = k;
                        1: k = k + {$urandom_range(255), $urandom()};
                        2: k = rand_key();
                        default: k = k + $urandom_range(1, 40);
                    endcase
                end
                repeat ($urandom_range(2, 8))
                    send_item(ACT_QUERY, pick_bound(0), pick_bound(1), $urandom_range(1));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, unused action, then a table spanning the full key range.
        send_item(ACT_QUERY, 5, 0, 1'b1);
        send_item(ACT_NOP, -1, -1, 1'b1);
        send_item(ACT_CLEAR, 0, 0, 1'b0);
        send_item(ACT_APPEND, 64'sh8000_0000_0000_0000, 0, 1'b0);
        send_item(ACT_APPEND, -5, 0, 1'b0);
        send_item(ACT_APPEND, 0, 0, 1'b0);
        send_item(ACT_APPEND, 7, 0, 1'b0);
        send_item(ACT_APPEND, 7, 0, 1'b0);
        send_item(ACT_APPEND, 100, 0, 1'b0);
        send_item(ACT_APPEND, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
        send_item(ACT_QUERY, 7, 0, 1'b0);
        send_item(ACT_QUERY, 7, -1, 1'b0);
        send_item(ACT_QUERY, -3, 0, 1'b0);
        send_item(ACT_QUERY, -100, 50, 1'b0);
        send_item(ACT_QUERY, 50, 60, 1'b0);
        send_item(ACT_QUERY, 50, 60, 1'b1);
        send_item(ACT_QUERY, 101, 99, 1'b0);
        send_item(ACT_QUERY, 64'sh7FFF_FFFF_FFFF_FFFF, -7, 1'b1);
        send_item(ACT_CLEAR, 0, 0, 1'b0);
        // Keys above every stored key, and a high bound below every key.
        send_item(ACT_APPEND, 10, 0, 1'b0);
        send_item(ACT_APPEND, 20, 0, 1'b0);
        send_item(ACT_QUERY, 30, 40, 1'b0);
        send_item(ACT_QUERY, 30, 40, 1'b1);
        send_item(ACT_QUERY, 1, 5, 1'b0);

        random_phase(260);
        send_idle_pct = 84;
        recv_idle_pct = 21;
        random_phase(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(256);
        i_s_tvalid <= 1'b0;

        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
